/* hw/rtl/address_keyed_count_table_unit_assert.svh */
// Assertion macros for the count table unit.
`ifndef ADDRESS_KEYED_COUNT_TABLE_UNIT_ASSERT_SVH
`define ADDRESS_KEYED_COUNT_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define AKCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AKCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AKCT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define AKCT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/akct_pkg.sv */
`default_nettype none
package akct_pkg;
   localparam int unsigned DefaultBuckets = 256;
   localparam int unsigned DefaultWays = 4;
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_ZERO_ADDRESS = 2'd1;
   localparam logic [1:0] STATUS_CONFLICT = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [63:0] address;
      logic [7:0]  length;
      logic [31:0] increment;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  stored_length;
      logic [31:0] stored_count;
      logic [1:0]  status;
   } rsp_type;
endpackage
`default_nettype wire

/* hw/rtl/akct_queue.sv */
`default_nettype none
// Two-entry queue between the front and the back part.
module akct_queue
   import akct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_word,
   output logic         out_valid,
   input  wire logic    out_ready,
   output req_type      out_word
);
   req_type    slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_word  = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_word;
   end
endmodule
`default_nettype wire

/* hw/rtl/akct_back.sv */
`default_nettype none
`include "address_keyed_count_table_unit_assert.svh"
// Table engine: clears the memory after reset, then reads a bucket, updates
// one way for a record and writes it back, one word at a time.
module akct_back
   import akct_pkg::*;
#(
   parameter int unsigned BUCKETS = DefaultBuckets,
   parameter int unsigned WAYS = DefaultWays
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_word,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_word
);
   localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef struct packed {
      logic        valid;
      logic [63:0] address;
      logic [7:0]  length;
      logic [31:0] count;
   } way_type;
   typedef way_type [WAYS-1:0] row_type;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   row_type    mem [BUCKETS];
   row_type    rd_row_ff;
   logic [1:0] state_ff, state_in;
   logic [BW:0] clr_ff, clr_in;
   req_type    cur_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       wr_en;
   logic [BW-1:0] wr_addr, bucket;
   row_type    wr_row;
   logic       take;

   // Bucket index is the address modulo the bucket count.
   assign bucket = BW'(in_word.address % 64'(BUCKETS));
   assign in_ready  = (state_ff == ST_IDLE);
   assign take      = in_valid && in_ready;
   assign out_valid = (state_ff == ST_OUT);
   assign out_word  = rsp_ff;

   // Lookup, insert and saturating add on the registered bucket row.
   always_comb begin
      logic hit, have_free;
      logic [WW-1:0] hit_w, free_w, sel;
      logic [32:0] sum;
      way_type e;
      hit = 1'b0; have_free = 1'b0;
      hit_w = '0; free_w = '0;
      sum = '0;
      rsp_in = '0;
      wr_row = rd_row_ff;
      wr_en = 1'b0;
      wr_addr = BW'(cur_ff.address % 64'(BUCKETS));
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row_ff[w].valid) begin
            if (!hit && rd_row_ff[w].address == cur_ff.address) begin
               hit = 1'b1; hit_w = WW'(w);
            end
         end else if (!have_free) begin
            have_free = 1'b1; free_w = WW'(w);
         end
      end
      sel = hit ? hit_w : free_w;
      e = rd_row_ff[sel];
      if (cur_ff.address == 64'd0) begin
         rsp_in.status = STATUS_ZERO_ADDRESS;
      end else if (cur_ff.kind == KIND_QUERY) begin
         if (hit) begin
            rsp_in.found = 1'b1;
            rsp_in.stored_length = e.length;
            rsp_in.stored_count = e.count;
         end
      end else if (!hit && !have_free) begin
         rsp_in.status = STATUS_FULL;
      end else begin
         if (hit) begin
            if (cur_ff.length != 8'd0) begin
               if (e.length == 8'd0) e.length = cur_ff.length;
               else if (e.length != cur_ff.length) rsp_in.status = STATUS_CONFLICT;
            end
         end else begin
            e.valid = 1'b1;
            e.address = cur_ff.address;
            e.length = cur_ff.length;
            e.count = 32'd0;
         end
         sum = {1'b0, e.count} + {1'b0, cur_ff.increment};
         e.count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         wr_row[sel] = e;
         rsp_in.found = hit;
         rsp_in.stored_length = e.length;
         rsp_in.stored_count = e.count;
      end
      if (state_ff == ST_READ && rsp_in.status != STATUS_FULL
          && cur_ff.kind == KIND_RECORD && cur_ff.address != 64'd0) wr_en = 1'b1;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff[BW-1:0];
         wr_row = '0;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (BW+1)'(BUCKETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (take) state_in = ST_READ;
         ST_READ: state_in = ST_OUT;
         ST_OUT:  if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= in_word;
         rd_row_ff <= mem[bucket];
      end
      if (wr_en) mem[wr_addr] <= wr_row;
      if (state_ff == ST_READ) rsp_ff <= rsp_in;
   end

   `AKCT_ASSERT_NXT(a_read_then_out, clock, reset, state_ff == ST_READ, state_ff == ST_OUT, "read not followed by result")
   `AKCT_ASSERT_IMP(a_no_take_in_clear, clock, reset, state_ff == ST_CLEAR, !in_ready, "item taken during clear")
   `AKCT_ASSERT_IMP(a_zero_status, clock, reset, out_valid && out_word.status == STATUS_ZERO_ADDRESS, !out_word.found, "zero address found")
endmodule
`default_nettype wire

/* hw/rtl/address_keyed_count_table_unit.sv */
`default_nettype none
// Address-keyed count table. Requests pass a two-word queue into a table
// engine that registers the bucket row when it takes a word, then writes back
// the updated way for a record and registers the response, and then presents
// the response until it is taken; the engine's sequencer takes one word,
// writes it back and holds its response in turn before it takes the next.
// After reset the engine clears the table, one bucket per cycle, from bucket
// 0 to BUCKETS-1; requests are queued but not processed during that pass.
module address_keyed_count_table_unit
   import akct_pkg::*;
#(
   parameter int unsigned BUCKETS = DefaultBuckets,
   parameter int unsigned WAYS = DefaultWays
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_word,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_word
);
   logic    q_valid, q_ready;
   req_type q_word;

   akct_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_word(req_word),
      .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
   );

   akct_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_word(rsp_word)
   );
endmodule
`default_nettype wire
